### hdl/sws_pkg.sv
// Package: shared constants, register indexes and the sine table generator.
package sws_pkg;

    // Default build parameters
    localparam int unsigned PHASE_BITS_DEF      = 32;
    localparam int unsigned TABLE_ADDR_BITS_DEF = 10;

    // Register port
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_INC = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE = 1'b1;

    localparam int unsigned  PHASE_INC_W   = 32;
    localparam int unsigned  SAMPLE_W      = 16;
    localparam int unsigned  MAG_W         = 15;
    localparam logic [PHASE_INC_W-1:0]     PHASE_INC_RST = '0;
    localparam logic signed [SAMPLE_W-1:0] AMPLITUDE_RST = 16'sd20000;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor denominators (2n)(2n+1), n = 1..8
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Quarter-wave table entry: round(32768 * sin(pi/2 * idx / 2^abits)),
    // clipped to 32767, using a Q30 Taylor series through x^17.
    // Evaluated at elaboration only.
    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned idx,
                                                    input int unsigned abits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        int                 n;
        x    = (HALF_PI_Q30 * 64'(idx)) >> abits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (n = 0; n < 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 64'sd32768 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767) begin
            v = 64'sd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

### hdl/sws_phase_acc.sv
// Wrapping phase accumulator, advanced once per accepted transaction.
module sws_phase_acc #(
    parameter int unsigned PHASE_BITS = sws_pkg::PHASE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step_en,
    input  logic [sws_pkg::PHASE_INC_W-1:0]    phase_inc,
    output logic [PHASE_BITS-1:0]              phase
);

    // Sum width covers both the accumulator and the 32-bit increment
    localparam int unsigned SUM_W =
        (PHASE_BITS > sws_pkg::PHASE_INC_W) ? PHASE_BITS : sws_pkg::PHASE_INC_W;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [SUM_W-1:0]      sum;

    // increment is zero-extended, sum taken modulo 2^PHASE_BITS
    assign sum        = SUM_W'(phase_reg) + SUM_W'(phase_inc);
    assign phase_next = step_en ? sum[PHASE_BITS-1:0] : phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule

### hdl/sws_sine_rom.sv
// Quarter-wave sine ROM, 2^ADDR_BITS+1 entries, registered read.
module sws_sine_rom #(
    parameter int unsigned ADDR_BITS = sws_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [ADDR_BITS:0]         rd_idx,
    output logic [sws_pkg::MAG_W-1:0]  rd_data
);

    localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

    logic [sws_pkg::MAG_W-1:0] rom [DEPTH];
    logic [sws_pkg::MAG_W-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_rom
        localparam logic [sws_pkg::MAG_W-1:0] ENTRY =
            sws_pkg::sine_entry(i, ADDR_BITS);
        assign rom[i] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sws_scale.sv
// Applies quadrant sign and amplitude, truncating the Q15 product toward zero.
module sws_scale (
    input  logic [sws_pkg::MAG_W-1:0]           mag,
    input  logic                                neg,
    input  logic signed [sws_pkg::SAMPLE_W-1:0] amplitude,
    output logic signed [sws_pkg::SAMPLE_W-1:0] sample
);

    localparam int unsigned PROD_W = 2 * sws_pkg::SAMPLE_W;

    logic signed [sws_pkg::SAMPLE_W-1:0] sine;
    logic signed [PROD_W-1:0]            prod;
    logic signed [PROD_W-1:0]            biased;

    assign sine   = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    assign prod   = PROD_W'(sine) * PROD_W'(amplitude);
    // divide by 2^15 rounding toward zero: bias negatives by 2^15-1
    assign biased = prod + (prod[PROD_W-1] ? PROD_W'(32'sd32767) : PROD_W'(32'sd0));
    assign sample = biased[30:15];

endmodule

### hdl/sine_wave_synthesizer_unit.sv
// Top level: direct digital synthesis sine oscillator with valid/ready channels.
//
// Usage:
//   Each transaction on the s_ channel requests one sample; s_last_in_block
//   rides along and comes back as m_last. The m_ channel returns one
//   signed 16-bit sample per request: amplitude * sin(phase), truncated
//   toward zero. The phase accumulator then advances by phase_increment.
//   Config: write register 0 (phase_increment = freq * 2^32 / rate) or
//   register 1 (amplitude, signed) with cfg_we/cfg_addr/cfg_wdata while idle.
// Pipeline: the accepting edge loads the ROM read register; the scaling/output
//   register loads from it when it is empty or being drained.
// Throughput: 1 transaction per cycle while m_ready keeps the output draining;
//   the phase add is the only feedback loop.
// Reset (aresetn low, synchronous): phase 0, phase_increment 0,
//   amplitude 20000, pipeline empty.
// Stall: when m_ready is low the output register holds its sample; the ROM
//   stage keeps taking requests until it too is full, then s_ready drops.
module sine_wave_synthesizer_unit #(
    parameter int unsigned PHASE_BITS      = sws_pkg::PHASE_BITS_DEF,
    parameter int unsigned TABLE_ADDR_BITS = sws_pkg::TABLE_ADDR_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // register write port
    input  logic                                 cfg_we,
    input  logic [sws_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [sws_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_last_in_block,
    // sample channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sws_pkg::SAMPLE_W-1:0]  m_sample,
    output logic                                 m_last
);

    // side info traveling alongside the ROM read
    typedef struct packed {
        logic neg;
        logic last;
    } lookup_t;

    localparam logic [TABLE_ADDR_BITS:0] QSTEPS = (TABLE_ADDR_BITS + 1)'(1) << TABLE_ADDR_BITS;

    // config registers
    logic [sws_pkg::PHASE_INC_W-1:0]     phase_inc_reg;
    logic signed [sws_pkg::SAMPLE_W-1:0] amplitude_reg;

    // pipeline control
    logic    s_accept;
    logic    out_load;
    logic    lk_valid_reg;
    logic    lk_valid_next;
    lookup_t lk_info_reg;
    logic    out_valid_reg;
    logic    out_valid_next;

    // datapath
    logic [PHASE_BITS-1:0]               phase;
    logic [1:0]                          quad;
    logic [TABLE_ADDR_BITS-1:0]          addr;
    logic [TABLE_ADDR_BITS:0]            rom_idx;
    logic [sws_pkg::MAG_W-1:0]           rom_mag;
    logic signed [sws_pkg::SAMPLE_W-1:0] scaled;
    logic signed [sws_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_inc_reg <= sws_pkg::PHASE_INC_RST;
            amplitude_reg <= sws_pkg::AMPLITUDE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                sws_pkg::REG_PHASE_INC: phase_inc_reg <= cfg_wdata;
                sws_pkg::REG_AMPLITUDE: amplitude_reg <= signed'(cfg_wdata[15:0]);
                default: ;
            endcase
        end
    end

    // output register loads whenever it is empty or being drained
    assign out_load = !out_valid_reg || m_ready;
    // lookup stage takes a request when empty or moving forward
    assign s_ready  = !lk_valid_reg || out_load;
    assign s_accept = s_valid && s_ready;

    assign lk_valid_next  = s_accept || (lk_valid_reg && !out_load);
    assign out_valid_next = out_load ? lk_valid_reg : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lk_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            lk_valid_reg  <= lk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // phase used for this sample is the value before the advance
    sws_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (s_accept),
        .phase_inc (phase_inc_reg),
        .phase     (phase)
    );

    // quadrant: odd quadrants run the table backward, upper half negates
    assign quad    = phase[PHASE_BITS-1 -: 2];
    assign addr    = phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign rom_idx = quad[0] ? (QSTEPS - {1'b0, addr}) : {1'b0, addr};

    sws_sine_rom #(
        .ADDR_BITS (TABLE_ADDR_BITS)
    ) u_sine_rom (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_idx  (rom_idx),
        .rd_data (rom_mag)
    );

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lk_info_reg.neg  <= quad[1];
            lk_info_reg.last <= s_last_in_block;
        end
    end

    sws_scale u_scale (
        .mag       (rom_mag),
        .neg       (lk_info_reg.neg),
        .amplitude (amplitude_reg),
        .sample    (scaled)
    );

    always_ff @(posedge aclk) begin
        if (out_load && lk_valid_reg) begin
            sample_reg <= scaled;
            last_reg   <= lk_info_reg.last;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_sample = sample_reg;
    assign m_last   = last_reg;

endmodule

### tb/tb_sine_wave_synthesizer_unit.sv
// Testbench for the DDS sine oscillator: queue-fed driver, self-predicting monitor.
module tb_sine_wave_synthesizer_unit;

    // Accumulator geometry for the default build.
    localparam int unsigned ACC_BITS      = sws_pkg::PHASE_BITS_DEF;
    localparam int unsigned LUT_BITS      = sws_pkg::TABLE_ADDR_BITS_DEF;
    localparam int unsigned QUARTER_STEPS = 1 << LUT_BITS;
    localparam int unsigned ADDR_LSB      = ACC_BITS - 2 - LUT_BITS;

    localparam int RESET_CYCLES   = 9;
    localparam int HOLD_CYCLES    = 64;   // long receiver hold-off for back-pressure
    localparam int SETTLE_CYCLES  = 4;    // pipeline is 2 deep, leave some margin
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 52;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic signed [sws_pkg::SAMPLE_W-1:0] sample;
        logic                                last;
    } sample_txn_t;

    // DUT connections; every input starts at a known value.
    logic                                aclk            = 1'b0;
    logic                                aresetn         = 1'b0;
    logic                                cfg_we          = 1'b0;
    logic [sws_pkg::CFG_ADDR_W-1:0]      cfg_addr        = '0;
    logic [sws_pkg::CFG_DATA_W-1:0]      cfg_wdata       = '0;
    logic                                s_valid         = 1'b0;
    logic                                s_ready;
    logic                                s_last_in_block = 1'b0;
    logic                                m_valid;
    logic                                m_ready         = 1'b0;
    logic signed [sws_pkg::SAMPLE_W-1:0] m_sample;
    logic                                m_last;

    // Stimulus and scoreboard state.
    logic          request_q [$];       // last_in_block of each pending request
    sample_txn_t   sample_expect_q [$]; // predicted samples, oldest first
    int            error_count    = 0;
    int            quiet_cycles   = 0;
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    int            hold_requests  = 0;
    int            hold_taken     = 0;
    int            hold_left      = 0;

    // Predictor state: own copy of the accumulator and registers.
    logic [14:0]                      quarter_wave [0:QUARTER_STEPS];
    logic [ACC_BITS-1:0]              phase_acc     = '0;
    logic [sws_pkg::PHASE_INC_W-1:0]  acc_advance   = sws_pkg::PHASE_INC_RST;
    int                               amp_gain      = int'(sws_pkg::AMPLITUDE_RST);

    sine_wave_synthesizer_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_last_in_block (s_last_in_block),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample        (m_sample),
        .m_last          (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Quarter-wave magnitude: round(32768*sin(pi/2 * i/Q)), Q30 Taylor series to x^17.
    function automatic int quarter_sine(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint          rounded;
        int unsigned     k;
        x    = (64'd1686629713 * longint'(i)) / QUARTER_STEPS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (acc * 32768 + (longint'(1) << 29)) >>> 30;
        if (rounded > 32767) begin
            rounded = 32767;
        end
        return int'(rounded);
    endfunction

    // Sample for the current phase, then advance the accumulator.
    function automatic sample_txn_t synth_next_sample(logic last_flag);
        sample_txn_t     txn;
        logic [1:0]      quadrant;
        int unsigned     lut_addr;
        int unsigned     lut_idx;
        int              sine_val;
        int              product;
        quadrant = phase_acc[ACC_BITS-1 -: 2];
        lut_addr = 32'(phase_acc[ADDR_LSB +: LUT_BITS]);
        lut_idx  = quadrant[0] ? (QUARTER_STEPS - lut_addr) : lut_addr;
        sine_val = int'(quarter_wave[lut_idx]);
        if (quadrant[1]) begin
            sine_val = -sine_val;
        end
        // int division truncates toward zero, matching the hardware spec
        product    = sine_val * amp_gain;
        txn.sample = sws_pkg::SAMPLE_W'(product / 32768);
        txn.last   = last_flag;
        phase_acc  = phase_acc + ACC_BITS'(acc_advance);
        return txn;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Request driver: valid stays up with a stable payload until the handshake.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                s_valid         <= 1'b1;
                s_last_in_block <= request_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Sample receiver: random stalls, plus a long hold-off on request so the
    // output register and ROM stage both fill and s_ready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: tracks register writes, predicts on each accepted request,
    // checks each accepted sample, and runs the watchdog.
    always @(posedge aclk) begin
        sample_txn_t want;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_addr)
                    sws_pkg::REG_PHASE_INC:
                        acc_advance = cfg_wdata[sws_pkg::PHASE_INC_W-1:0];
                    sws_pkg::REG_AMPLITUDE:
                        amp_gain = int'($signed(cfg_wdata[sws_pkg::SAMPLE_W-1:0]));
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (sample_expect_q.size() == 0) begin
                    report_error($sformatf("unexpected transaction sample=%0d last=%0b",
                                           m_sample, m_last));
                end else begin
                    want = sample_expect_q.pop_front();
                    if (m_sample !== want.sample) begin
                        report_error($sformatf("sample got %0d want %0d",
                                               m_sample, want.sample));
                    end
                    if (m_last !== want.last) begin
                        report_error($sformatf("last got %0b want %0b", m_last, want.last));
                    end
                end
            end

            if (s_valid && s_ready) begin
                sample_expect_q.push_back(synth_next_sample(s_last_in_block));
            end

            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sine_wave_synthesizer_unit test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Register write, one cycle of cfg_we.
    task automatic write_reg(input logic [sws_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [sws_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        @(negedge aclk);
        case (mode)
            IDLE_NONE:     begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 76; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 76; end
            IDLE_BOTH:     begin send_gap_pct = 31; recv_stall_pct = 31; end
            default:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // last_odds == 0 alternates the flag; otherwise it is set one time in last_odds.
    task automatic queue_requests(input int count, input int last_odds);
        int i;
        @(negedge aclk);
        for (i = 0; i < count; i++) begin
            if (last_odds == 0) begin
                request_q.push_back(i[0]);
            end else begin
                request_q.push_back($urandom_range(last_odds - 1) == 0);
            end
        end
    endtask

    // Idle means: no request pending or offered and every sample returned.
    task automatic wait_idle;
        do begin
            @(negedge aclk);
        end while (request_q.size() != 0 || s_valid || sample_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int                             p;
        int unsigned                    i;
        logic [sws_pkg::CFG_DATA_W-1:0] inc_val;
        logic [sws_pkg::CFG_DATA_W-1:0] amp_val;

        for (i = 0; i <= QUARTER_STEPS; i++) begin
            quarter_wave[i] = 15'(quarter_sine(i));
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: zero increment keeps phase at 0, default amplitude.
        set_idling(IDLE_NONE);
        queue_requests(2, 0);
        wait_idle();

        // Quarter-turn steps at full positive amplitude: hits each quadrant,
        // including the table end entry at the sine peaks.
        write_reg(sws_pkg::REG_PHASE_INC, 32'h4000_0000);
        write_reg(sws_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
        queue_requests(5, 0);
        wait_idle();

        // Most negative amplitude against the peak: the full-scale product case.
        write_reg(sws_pkg::REG_PHASE_INC, 32'h1000_0000);
        write_reg(sws_pkg::REG_AMPLITUDE, 32'hFFFF_8000);
        queue_requests(9, 0);
        wait_idle();

        // Largest increment (wraps by one step backward), zero amplitude.
        write_reg(sws_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
        write_reg(sws_pkg::REG_AMPLITUDE, 32'h0000_0000);
        queue_requests(3, 0);
        wait_idle();

        // Half-turn increment, amplitude -1; upper data bits must be ignored.
        write_reg(sws_pkg::REG_PHASE_INC, 32'h8000_0000);
        write_reg(sws_pkg::REG_AMPLITUDE, 32'hA5A5_FFFF);
        queue_requests(4, 0);
        wait_idle();

        // Random phases: new settings each time, idling pattern rotates.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(4))
                0:       inc_val = $urandom();
                1:       inc_val = $urandom_range(32'h00FF_FFFF);   // audio-range tones
                2:       inc_val = 32'hFFFF_FFFF;
                3:       inc_val = $urandom_range(32'h0030_0000);   // near single-step
                default: inc_val = '0;
            endcase
            amp_val = $urandom();
            case ($urandom_range(3))
                0:       amp_val[15:0] = 16'h8000;
                1:       amp_val[15:0] = 16'h7FFF;
                2:       amp_val[15:0] = 16'($urandom_range(255));
                default: ;
            endcase
            write_reg(sws_pkg::REG_PHASE_INC, inc_val);
            write_reg(sws_pkg::REG_AMPLITUDE, amp_val);

            set_idling(idle_mode_t'(p % 4));
            if (p == 4) begin
                // receiver goes quiet while requests keep coming
                hold_requests = hold_requests + 1;
            end
            queue_requests(PHASE_ITEMS, (p % 3 == 0) ? 2 : 8);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("sine_wave_synthesizer_unit test passed");
        end else begin
            $display("sine_wave_synthesizer_unit test failed");
        end
        $finish;
    end

endmodule

### sine_wave_synthesizer_unit.f
hdl/sws_pkg.sv
hdl/sws_phase_acc.sv
hdl/sws_sine_rom.sv
hdl/sws_scale.sv
hdl/sine_wave_synthesizer_unit.sv
tb/tb_sine_wave_synthesizer_unit.sv
